@@ rtl/line_assembly_buffer_defines.svh @@
// assertion macros shared by the line assembly buffer rtl
`ifndef LINE_ASSEMBLY_BUFFER_DEFINES_SVH
`define LINE_ASSEMBLY_BUFFER_DEFINES_SVH

// same-cycle implication on clk, held off during reset
`define LAB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, held off during reset
`define LAB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lab_pkg.sv @@
// types and constants of the line assembly buffer
package lab_pkg;

  localparam int unsigned CNT_W = 7;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_BYTE  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [7:0] max_len;
  } lab_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       data_byte;
    logic             last;
    logic [CNT_W-1:0] copied_count;
  } lab_out_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_EMPTY,
    CMD_COPY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [CNT_W-1:0] count;
  } lab_cmd_t;

endpackage

@@ rtl/lab_ram.sv @@
// generic single-write single-read ram with registered read
module lab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lab_cmd_fifo.sv @@
// two-entry queue of read commands between front and back
`include "line_assembly_buffer_defines.svh"

module lab_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lab_pkg::lab_cmd_t din,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output lab_pkg::lab_cmd_t dout
);
  import lab_pkg::*;

  lab_cmd_t   slot0_r, slot1_r;
  lab_cmd_t   slot0_nxt, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] wr_pos;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = slot0_r;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    wr_pos    = cnt_r - {1'b0, pop};
    if (pop) begin
      slot0_nxt = slot1_r;
    end
    if (push) begin
      if (wr_pos == 2'd0) begin
        slot0_nxt = din;
      end else begin
        slot1_nxt = din;
      end
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  `LAB_ASSERT_NOW(a_fifo_no_overflow, push, !full || pop, "command pushed into full queue")
  `LAB_ASSERT_NOW(a_fifo_no_underflow, pop, !empty, "command popped from empty queue")

endmodule

@@ rtl/lab_front.sv @@
// request intake: line assembly and read classification
`include "line_assembly_buffer_defines.svh"

module lab_front #(
  parameter int unsigned BUF_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lab_pkg::lab_in_t            in_data,
  output logic                        ram_we,
  output logic [$clog2(BUF_SIZE)-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata,
  output logic                        cmd_push,
  output lab_pkg::lab_cmd_t           cmd_data,
  input  logic                        cmd_full,
  input  logic                        copy_done
);
  import lab_pkg::*;

  localparam int unsigned POS_W = $clog2(BUF_SIZE);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BUF_SIZE - 1);

  logic [POS_W-1:0] wr_pos_r, wr_pos_nxt;
  logic [POS_W-1:0] line_len_r, line_len_nxt;
  logic             line_rdy_r, line_rdy_nxt;
  logic             copy_busy_r, copy_busy_nxt;
  logic             acc;
  logic             is_term;
  logic [7:0]       limit, len8, n8;

  // stall everything while a copy still reads the store or the command queue is full
  assign in_ready  = !copy_busy_r && !cmd_full;
  assign acc       = in_valid && in_ready;
  assign is_term   = (in_data.rx_byte == CHAR_CR) || (in_data.rx_byte == CHAR_LF);
  assign ram_waddr = wr_pos_r;
  assign ram_wdata = in_data.rx_byte;

  always_comb begin
    wr_pos_nxt    = wr_pos_r;
    line_len_nxt  = line_len_r;
    line_rdy_nxt  = line_rdy_r;
    copy_busy_nxt = copy_busy_r;
    ram_we        = 1'b0;
    cmd_push      = 1'b0;
    cmd_data.kind  = CMD_NONE;
    cmd_data.count = '0;
    limit = (in_data.max_len == 8'd0) ? 8'd0 : in_data.max_len - 8'd1;
    len8  = 8'(line_len_r);
    n8    = (len8 < limit) ? len8 : limit;
    if (copy_done) begin
      copy_busy_nxt = 1'b0;
    end
    if (acc) begin
      if (in_data.action == ACT_BYTE) begin
        if (!line_rdy_r) begin
          if (is_term) begin
            if (wr_pos_r != '0) begin
              line_len_nxt = wr_pos_r;
              line_rdy_nxt = 1'b1;
            end
            wr_pos_nxt = '0;
          end else if (wr_pos_r < LAST_POS) begin
            ram_we     = 1'b1;
            wr_pos_nxt = wr_pos_r + POS_W'(1);
          end else begin
            // overflow drops the partial line silently
            wr_pos_nxt = '0;
          end
        end
      end else begin
        cmd_push = 1'b1;
        if (line_rdy_r) begin
          line_rdy_nxt = 1'b0;
          line_len_nxt = '0;
          cmd_data.count = CNT_W'(n8);
          if (n8 == 8'd0) begin
            cmd_data.kind = CMD_EMPTY;
          end else begin
            cmd_data.kind = CMD_COPY;
            copy_busy_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r    <= '0;
      line_len_r  <= '0;
      line_rdy_r  <= 1'b0;
      copy_busy_r <= 1'b0;
    end else begin
      wr_pos_r    <= wr_pos_nxt;
      line_len_r  <= line_len_nxt;
      line_rdy_r  <= line_rdy_nxt;
      copy_busy_r <= copy_busy_nxt;
    end
  end

  `LAB_ASSERT_NOW(a_done_while_busy, copy_done, copy_busy_r, "copy finished with none pending")

endmodule

@@ rtl/lab_back.sv @@
// result sequencer: streams copied bytes from the store, or gives one none or empty result
`include "line_assembly_buffer_defines.svh"

module lab_back #(
  parameter int unsigned BUF_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_empty,
  input  lab_pkg::lab_cmd_t           cmd_data,
  output logic                        cmd_pop,
  output logic                        ram_re,
  output logic [$clog2(BUF_SIZE)-1:0] ram_raddr,
  input  logic [7:0]                  ram_rdata,
  output logic                        copy_done,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lab_pkg::lab_out_t           out_data
);
  import lab_pkg::*;

  localparam int unsigned POS_W = $clog2(BUF_SIZE);

  typedef enum logic {
    B_IDLE,
    B_COPY
  } state_t;

  state_t           state_r;
  logic [POS_W-1:0] n_r, rd_idx_r, sent_r;
  logic             rd_pend_r;
  logic             out_valid_r;
  lab_out_t         out_r;
  logic             out_free, mv, iss, is_last, out_load;

  assign out_free  = !out_valid_r || out_ready;
  assign mv        = (state_r == B_COPY) && rd_pend_r && out_free;
  assign iss       = (state_r == B_COPY) && (rd_idx_r != n_r) && (!rd_pend_r || mv);
  assign cmd_pop   = (state_r == B_IDLE) && !cmd_empty &&
                     ((cmd_data.kind == CMD_COPY) || out_free);
  assign out_load  = (cmd_pop && (cmd_data.kind != CMD_COPY)) || mv;
  assign is_last   = (sent_r == n_r - POS_W'(1));
  assign copy_done = mv && is_last;
  assign ram_re    = iss;
  assign ram_raddr = rd_idx_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result takes the register, else an accepted one leaves it
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      rd_pend_r <= iss || (rd_pend_r && !mv);
      if (cmd_pop) begin
        unique case (cmd_data.kind)
          CMD_COPY: begin
            state_r  <= B_COPY;
            n_r      <= POS_W'(cmd_data.count);
            rd_idx_r <= '0;
            sent_r   <= '0;
          end
          CMD_EMPTY: begin
            out_r.status       <= ST_EMPTY;
            out_r.data_byte    <= 8'd0;
            out_r.last         <= 1'b1;
            out_r.copied_count <= '0;
          end
          default: begin
            out_r.status       <= ST_NONE;
            out_r.data_byte    <= 8'd0;
            out_r.last         <= 1'b1;
            out_r.copied_count <= '0;
          end
        endcase
      end
      if (iss) begin
        rd_idx_r <= rd_idx_r + POS_W'(1);
      end
      if (mv) begin
        out_r.status       <= ST_BYTE;
        out_r.data_byte    <= ram_rdata;
        out_r.last         <= is_last;
        out_r.copied_count <= CNT_W'(n_r);
        sent_r             <= sent_r + POS_W'(1);
        if (is_last) begin
          state_r <= B_IDLE;
        end
      end
    end
  end

  `LAB_ASSERT_NOW(a_pend_in_copy, rd_pend_r, state_r == B_COPY, "read pending outside copy")
  `LAB_ASSERT_NOW(a_multi_is_byte, out_valid_r && !out_r.last, out_r.status == ST_BYTE,
                  "non-final result that is not a line byte")
  `LAB_ASSERT_NEXT(a_done_to_idle, copy_done, state_r == B_IDLE && !rd_pend_r,
                   "sequencer not idle after final byte")

endmodule

@@ rtl/line_assembly_buffer.sv @@
// top level of the line assembly buffer
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------------
//  input   | in_valid, in_ready, in_data    | received byte or read request
//  result  | out_valid, out_ready, out_data | status, line byte, last, copied count
//
// a received byte builds the line in the store; a read request is queued
// a copy streams one byte per cycle through the store's registered read port
// while the receiver keeps taking results; a result left waiting holds the copy
// new requests stall while a copy is in flight, since it still reads the store
// synchronous active-low reset clears control; the store needs no clearing
// the output register lets the next request enter while a result waits
module line_assembly_buffer #(
  parameter int unsigned BUF_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lab_pkg::lab_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lab_pkg::lab_out_t out_data
);
  import lab_pkg::*;

  localparam int unsigned POS_W = $clog2(BUF_SIZE);

  // store write port, driven by the front
  logic             ram_we;
  logic [POS_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  // store read port, driven by the back
  logic             ram_re;
  logic [POS_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  // command queue
  logic             cmd_push, cmd_pop, cmd_full, cmd_empty;
  lab_cmd_t         cmd_in, cmd_out;
  // copy completion back to the front
  logic             copy_done;

  // front: builds the line and classifies each read request
  lab_front #(
    .BUF_SIZE (BUF_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in),
    .cmd_full  (cmd_full),
    .copy_done (copy_done)
  );

  // short queue decoupling intake from result streaming
  lab_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_out)
  );

  // line store
  lab_ram #(
    .WIDTH (8),
    .DEPTH (BUF_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // back: turns commands into result items
  lab_back #(
    .BUF_SIZE (BUF_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .copy_done (copy_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ test/lab_checker.sv @@
// checker of the line assembly buffer: predicts each read and compares results
module lab_checker #(
  parameter int unsigned BUF_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  lab_pkg::lab_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  lab_pkg::lab_out_t out_data,
  output int unsigned       fail_count,
  output int unsigned       waiting
);
  import lab_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  // private copy of the line state
  logic [7:0]       line_bytes [BUF_SIZE];
  logic [CNT_W-1:0] fill_pos;
  logic             line_held;
  logic [CNT_W-1:0] held_len;

  lab_out_t    line_results [$];
  int unsigned mismatches = 0;

  task automatic model_request(input lab_in_t req);
    int unsigned room;
    int unsigned n;
    int unsigned i;
    lab_out_t    res;
    if (req.action == ACT_BYTE) begin
      if (line_held) return;
      if (req.rx_byte == CHAR_CR || req.rx_byte == CHAR_LF) begin
        if (fill_pos != '0) begin
          held_len  = fill_pos;
          line_held = 1'b1;
        end
        fill_pos = '0;
      end else if (fill_pos < BUF_SIZE - 1) begin
        line_bytes[fill_pos] = req.rx_byte;
        fill_pos = fill_pos + 1'b1;
      end else begin
        // overflow drops the partial line silently
        fill_pos = '0;
      end
      return;
    end
    res      = '0;
    res.last = 1'b1;
    if (!line_held) begin
      res.status = ST_NONE;
      line_results.push_back(res);
      return;
    end
    room = (req.max_len == 8'd0) ? 0 : req.max_len - 1;
    n    = (held_len < room) ? held_len : room;
    if (n > BUF_SIZE - 1) n = BUF_SIZE - 1;
    line_held = 1'b0;
    held_len  = '0;
    if (n == 0) begin
      res.status = ST_EMPTY;
      line_results.push_back(res);
      return;
    end
    for (i = 0; i < n; i++) begin
      res.status       = ST_BYTE;
      res.data_byte    = line_bytes[i];
      res.last         = (i + 1 == n);
      res.copied_count = CNT_W'(n);
      line_results.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    lab_out_t want;
    if (!rst_n) begin
      fill_pos  = '0;
      line_held = 1'b0;
      held_len  = '0;
      line_results.delete();
    end else begin
      if (in_valid && in_ready) model_request(in_data);
      if (out_valid && out_ready) begin
        if (line_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: status %0d data %h last %b count %0d",
                     out_data.status, out_data.data_byte, out_data.last,
                     out_data.copied_count);
        end else begin
          want = line_results.pop_front();
          if (out_data.status !== want.status || out_data.data_byte !== want.data_byte ||
              out_data.last !== want.last ||
              out_data.copied_count !== want.copied_count) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("result mismatch: expected %0d/%h/%b/%0d, got %0d/%h/%b/%0d",
                       want.status, want.data_byte, want.last, want.copied_count,
                       out_data.status, out_data.data_byte, out_data.last,
                       out_data.copied_count);
          end
        end
      end
    end
    waiting    <= line_results.size();
    fail_count <= mismatches;
  end

endmodule

@@ test/tb_top.sv @@
// top of the line assembly buffer testbench: stimulus, watchdog and verdict
module tb_top;
  import lab_pkg::*;

  localparam int unsigned BUF_SIZE     = 64;
  localparam int unsigned RANDOM_SEQS  = 5;    // long line, overflow, drain, two random ones
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned HOLD_CYCLES  = 150;  // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 80;   // a full copy plus pipeline slack
  localparam int unsigned QUIET_LIMIT  = 3000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  lab_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lab_out_t out_data;

  int unsigned fail_count;
  int unsigned waiting;
  int unsigned quiet_cycles = 0;

  // shared between sender and receiver: calm turns idling off on both
  // sides, hold_go starts the one long receiver hold-off
  logic calm    = 1'b0;
  logic hold_go = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  line_assembly_buffer #(
    .BUF_SIZE(BUF_SIZE)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  lab_checker #(
    .BUF_SIZE(BUF_SIZE)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .waiting   (waiting)
  );

  // any byte that does not end a line
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CHAR_CR || b == CHAR_LF) b = 8'($urandom_range(255));
    return b;
  endfunction

  function automatic logic [7:0] line_end();
    return $urandom_range(1) ? CHAR_CR : CHAR_LF;
  endfunction

  // reader buffer size: mostly roomy, often any size, sometimes eight or less
  function automatic logic [7:0] reader_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return 8'd255;
    if (pick < 75) return 8'($urandom_range(255));
    return 8'($urandom_range(8));
  endfunction

  // offer one request; random gaps before it unless calm
  // valid stays high until the edge where the request is taken
  task automatic send_request(input lab_in_t req);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // max_len is don't-care for a byte, still randomized so its bits toggle
  task automatic send_byte(input logic [7:0] b);
    lab_in_t req;
    req.action  = ACT_BYTE;
    req.rx_byte = b;
    req.max_len = 8'($urandom_range(255));
    send_request(req);
  endtask

  task automatic send_read(input logic [7:0] size);
    lab_in_t req;
    req.action  = ACT_READ;
    req.rx_byte = 8'($urandom_range(255));
    req.max_len = size;
    send_request(req);
  endtask

  task automatic send_text(input int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) send_byte(text_byte());
  endtask

  // drop valid and wait until every expected result is out
  // the first edge lets the checker book the last request
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // receiver: random ready, one long hold-off counted here, no idling when calm
  initial begin : receiver
    logic held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog: cycles in which neither channel moves anything
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : sender
    int unsigned seq;
    int unsigned kind;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    send_read(8'd255);        // nothing ready yet
    send_byte(CHAR_LF);       // empty line, terminator only
    send_byte(CHAR_CR);
    send_read(8'hFF);
    send_byte(8'h00);         // extreme byte values inside a line
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(CHAR_CR);       // line of three ready
    send_byte(8'h42);         // dropped while the line is ready
    send_byte(CHAR_LF);       // terminator dropped too
    send_read(8'd1);          // room for nothing: freed, zero copied
    send_read(8'd255);        // read after free sees no line
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(CHAR_LF);
    send_read(8'd0);          // zero size acts like one
    send_byte(8'h01);
    send_byte(8'hFE);
    send_byte(CHAR_CR);
    send_read(8'd2);          // truncated to one byte
    send_byte(8'h33);
    send_byte(8'hCC);
    send_byte(CHAR_LF);
    send_read(8'd255);        // whole line of two

    // ---- random part ----
    seq = 0;
    while (seq < RANDOM_SEQS) begin
      calm = (seq == 1);
      if (seq == 0) begin
        // longest line, read in full while the receiver is held off,
        // so the copy jams and later requests back up at the input
        send_text(BUF_SIZE - 1);
        send_byte(line_end());
        hold_go = 1'b1;
        send_read(8'($urandom_range(255, BUF_SIZE)));
      end else if (seq == 1) begin
        // offered back to back against the jammed copy
        // one byte past the limit throws the partial line away
        send_text(BUF_SIZE);
        send_text($urandom_range(3, 1));
        send_byte(line_end());
        send_read(reader_size());
      end else if (seq == 2) begin
        drain_results();
      end else begin
        kind = $urandom_range(99);
        if (kind < 58) begin
          send_text($urandom_range(6, 1));
          send_byte(line_end());
          send_read(reader_size());
        end else if (kind < 68) begin
          // bytes of any value, terminators too, while the line waits
          send_text($urandom_range(6, 1));
          send_byte(line_end());
          send_byte(8'($urandom_range(255)));
          send_byte($urandom_range(1) ? line_end() : text_byte());
          send_read(reader_size());
        end else if (kind < 76) begin
          send_byte(line_end());
          send_read(reader_size());
        end else if (kind < 84) begin
          // a line read twice: the second read finds nothing
          send_text($urandom_range(4, 1));
          send_byte(line_end());
          send_read(reader_size());
          send_read(reader_size());
        end else if (kind < 94) begin
          // unterminated fragment, carried into the next line
          send_text($urandom_range(4, 1));
        end else begin
          send_text($urandom_range(BUF_SIZE + 4, 20));
          send_byte(line_end());
          send_read(reader_size());
        end
      end
      seq++;
    end
    calm = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
